[design/mstt_pkg.sv]
// ----------------------------------------------------------------------------
// mstt_pkg: shared types and constants of the timer slot table
// Slot count, field widths, command codes, slot modes and the records
// that travel between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package mstt_pkg;

  // table size and derived index width
  localparam int SLOTS     = 16;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IDX_EXT_W = 7;

  // fixed field widths
  localparam int CMD_W      = 3;
  localparam int SLOT_FLD_W = 4;
  localparam int TIME_W     = 16;
  localparam int REP_W      = 8;
  localparam int MASK_W     = 16;
  localparam int MASK_IDX_W = 4;
  localparam int GRANT_W    = 4;
  localparam int VALUE_W    = 16;

  // stream widths
  localparam int IN_USER_W  = 8;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  // command queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [REP_W-1:0] REPEAT_FOREVER = 8'hFF;

  // command codes on the input
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_START  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

  // slot modes
  typedef enum logic [1:0] {
    MODE_FREE    = 2'd0,
    MODE_STOPPED = 2'd1,
    MODE_RUNNING = 2'd2
  } mode_e;

  // classified command kinds
  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_ADD    = 3'd1,
    KIND_START  = 3'd2,
    KIND_STOP   = 3'd3,
    KIND_DELETE = 3'd4,
    KIND_NONE   = 3'd5
  } kind_e;

  // classified request from front to back
  typedef struct packed {
    kind_e               kind;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   interval;
    logic [REP_W-1:0]    count;
    logic [VALUE_W-1:0]  tval;
  } cmd_t;

  // result record
  typedef struct packed {
    logic [VALUE_W-1:0] expired_value;
    logic [MASK_W-1:0]  expired_mask;
    logic               table_full;
    logic [GRANT_W-1:0] granted_slot;
  } res_t;

endpackage

[design/multi_slot_repeating_timer_table.sv]
// ----------------------------------------------------------------------------
// multi_slot_repeating_timer_table: repeating timer slot table
// Start, stop, delete and unknown codes are handled in the single-slot state;
// add and tick run as a one-slot-per-cycle sweep. A new request is taken only
// after the last one has written its result and the output register is free.
// Reset: asynchronous, clears all slots to free and empties the queue.
// ----------------------------------------------------------------------------
module multi_slot_repeating_timer_table (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [mstt_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // slot, interval, repeat_count, tick_value
  input  logic [mstt_pkg::IN_USER_W-1:0]   s_axis_tuser,  // cmd
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [mstt_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // granted_slot, table_full, expired_mask, expired_value
);
  import mstt_pkg::*;

  logic push, full, q_valid, pop;
  cmd_t push_cmd, q_cmd;

  // intake and classification
  mstt_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_o        (push),
    .push_cmd_o    (push_cmd),
    .full_i        (full)
  );

  // request queue
  mstt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .valid_o    (q_valid),
    .pop_cmd_o  (q_cmd),
    .pop_i      (pop)
  );

  // execution and result
  mstt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (q_cmd),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[design/mstt_front.sv]
// ----------------------------------------------------------------------------
// mstt_front: request intake and classification
// Unpacks the input stream, decodes the command and checks the slot
// number against the table size before handing it to the queue.
// ----------------------------------------------------------------------------
module mstt_front (
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [mstt_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // slot, interval, repeat_count, tick_value
  input  logic [mstt_pkg::IN_USER_W-1:0]   s_axis_tuser,  // cmd
  output logic                             push_o,
  output mstt_pkg::cmd_t                   push_cmd_o,
  input  logic                             full_i
);
  import mstt_pkg::*;

  logic [CMD_W-1:0]      cmd;
  logic [SLOT_FLD_W-1:0] slot;
  logic                  in_range;
  kind_e                 kind;

  // field unpacking
  assign cmd  = s_axis_tuser[CMD_W-1:0];
  assign slot = s_axis_tdata[SLOT_FLD_W-1:0];
  assign push_cmd_o.interval = s_axis_tdata[SLOT_FLD_W +: TIME_W];
  assign push_cmd_o.count    = s_axis_tdata[SLOT_FLD_W+TIME_W +: REP_W];
  assign push_cmd_o.tval     = s_axis_tdata[SLOT_FLD_W+TIME_W+REP_W +: VALUE_W];
  assign push_cmd_o.slot     = SLOT_W'(slot);
  assign push_cmd_o.kind     = kind;

  assign in_range = (32'(slot) < SLOTS);

  // command classification
  always_comb begin
    case (cmd)
      CMD_TICK:   kind = KIND_TICK;
      CMD_ADD:    kind = KIND_ADD;
      CMD_START:  kind = in_range ? KIND_START : KIND_NONE;
      CMD_STOP:   kind = in_range ? KIND_STOP : KIND_NONE;
      CMD_DELETE: kind = in_range ? KIND_DELETE : KIND_NONE;
      default:    kind = KIND_NONE;
    endcase
  end

  // handshake
  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

endmodule

[design/mstt_queue.sv]
// ----------------------------------------------------------------------------
// mstt_queue: short request queue
// Holds classified requests between the front end and the back end so
// that either side can stall on its own.
// ----------------------------------------------------------------------------
module mstt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mstt_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  output logic           valid_o,
  output mstt_pkg::cmd_t pop_cmd_o,
  input  logic           pop_i
);
  import mstt_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[design/mstt_back.sv]
// ----------------------------------------------------------------------------
// mstt_back: slot table and command execution
// Holds the slot table, runs add and tick as one-slot-per-cycle sweeps,
// applies single-slot commands and drives the output register.
// ----------------------------------------------------------------------------
module mstt_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  mstt_pkg::cmd_t                  q_cmd_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mstt_pkg::OUT_DATA_W-1:0] m_axis_tdata   // granted_slot, table_full, expired_mask, expired_value
);
  import mstt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ONE  = 4'b0010,
    S_TICK = 4'b0100,
    S_ADD  = 4'b1000
  } state_e;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  cmd_t              cur_q, cur_d;
  logic [MASK_W-1:0] mask_q, mask_d;

  mode_e             mode_q [SLOTS];
  logic [TIME_W-1:0] tl_q   [SLOTS];
  logic [TIME_W-1:0] rl_q   [SLOTS];
  logic [REP_W-1:0]  rp_q   [SLOTS];

  mode_e             mode_rd;
  logic [TIME_W-1:0] tl_rd, rl_rd, tl_dec;
  logic [REP_W-1:0]  rp_rd, rp_dec;
  logic [IDX_EXT_W-1:0] idx_ext;

  logic              wr_en;
  mode_e             wr_mode;
  logic [TIME_W-1:0] wr_tl, wr_rl;
  logic [REP_W-1:0]  wr_rp;

  logic              res_we;
  res_t              res_d;
  logic              out_valid_q;
  res_t              out_q;
  logic              out_free;

  // current slot read
  assign mode_rd = mode_q[idx_q];
  assign tl_rd   = tl_q[idx_q];
  assign rl_rd   = rl_q[idx_q];
  assign rp_rd   = rp_q[idx_q];
  assign tl_dec  = tl_rd - 16'd1;
  assign rp_dec  = rp_rd - 8'd1;
  assign idx_ext = IDX_EXT_W'(idx_q);

  assign out_free = !out_valid_q || m_axis_tready;

  // sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    mask_d  = mask_q;
    pop_o   = 1'b0;
    wr_en   = 1'b0;
    wr_mode = mode_rd;
    wr_tl   = tl_rd;
    wr_rl   = rl_rd;
    wr_rp   = rp_rd;
    res_we  = 1'b0;
    res_d   = '0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          pop_o  = 1'b1;
          cur_d  = q_cmd_i;
          mask_d = '0;
          case (q_cmd_i.kind)
            KIND_TICK: begin
              idx_d   = '0;
              state_d = S_TICK;
            end
            KIND_ADD: begin
              idx_d   = '0;
              state_d = S_ADD;
            end
            default: begin
              idx_d   = q_cmd_i.slot;
              state_d = S_ONE;
            end
          endcase
        end
      end
      S_ONE: begin
        case (cur_q.kind)
          KIND_START: begin
            if (mode_rd != MODE_FREE) begin
              wr_en   = 1'b1;
              wr_tl   = rl_rd;
              wr_mode = MODE_RUNNING;
            end
          end
          KIND_STOP: begin
            if (mode_rd != MODE_FREE) begin
              wr_en   = 1'b1;
              wr_mode = MODE_STOPPED;
            end
          end
          KIND_DELETE: begin
            wr_en   = 1'b1;
            wr_mode = MODE_FREE;
            wr_tl   = '0;
            wr_rl   = '0;
            wr_rp   = '0;
          end
          default: ;
        endcase
        res_we  = 1'b1;
        state_d = S_IDLE;
      end
      S_TICK: begin
        // free spent stopped slots, count running ones down
        if (mode_rd == MODE_STOPPED && rp_rd == '0) begin
          wr_en   = 1'b1;
          wr_mode = MODE_FREE;
          wr_tl   = '0;
          wr_rl   = '0;
          wr_rp   = '0;
        end else if (mode_rd == MODE_RUNNING && tl_rd != '0) begin
          wr_en = 1'b1;
          wr_tl = tl_dec;
          if (tl_dec == '0) begin
            if (rp_rd == REPEAT_FOREVER) begin
              wr_tl = rl_rd;
            end else if (rp_rd != '0) begin
              wr_tl = rl_rd;
              wr_rp = rp_dec;
            end
            if (rp_rd == 8'd0 || rp_rd == 8'd1) begin
              wr_mode = MODE_STOPPED;
            end
            if (idx_ext < IDX_EXT_W'(MASK_W)) begin
              mask_d[idx_ext[MASK_IDX_W-1:0]] = 1'b1;
            end
          end
        end
        if (idx_q == LAST_IDX) begin
          res_we              = 1'b1;
          res_d.expired_mask  = mask_d;
          res_d.expired_value = (mask_d != '0) ? cur_q.tval : '0;
          state_d             = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_ADD: begin
        // claim the lowest free slot
        if (mode_rd == MODE_FREE) begin
          wr_en              = 1'b1;
          wr_mode            = MODE_STOPPED;
          wr_tl              = cur_q.interval;
          wr_rl              = cur_q.interval;
          wr_rp              = cur_q.count;
          res_we             = 1'b1;
          res_d.granted_slot = idx_ext[GRANT_W-1:0];
          state_d            = S_IDLE;
        end else if (idx_q == LAST_IDX) begin
          res_we           = 1'b1;
          res_d.table_full = 1'b1;
          state_d          = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (res_we) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    mask_q <= mask_d;
    if (res_we) begin
      out_q <= res_d;
    end
  end

  // slot table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        mode_q[i] <= MODE_FREE;
        tl_q[i]   <= '0;
        rl_q[i]   <= '0;
        rp_q[i]   <= '0;
      end
    end else if (wr_en) begin
      mode_q[idx_q] <= wr_mode;
      tl_q[idx_q]   <= wr_tl;
      rl_q[idx_q]   <= wr_rl;
      rp_q[idx_q]   <= wr_rp;
    end
  end

  // output stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.expired_value, out_q.expired_mask,
                          out_q.table_full, out_q.granted_slot};

endmodule

[dv/tb_multi_slot_repeating_timer_table.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_slot_repeating_timer_table: self-checking bench of the timer table
// Drives add, start, stop, delete, tick and unused command codes on the
// request stream. It keeps its own copy of the slot table to predict every
// response, and checks the responses in order, field by field. The random
// traffic mostly targets occupied slots, and runs with several idle and
// stall mixes on both sides.
// ----------------------------------------------------------------------------
module tb_multi_slot_repeating_timer_table;
  import mstt_pkg::*;

  // unused command codes, which must leave the table alone
  localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = CMD_DELETE + 3'd1;
  localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = '1;

  // one slot of the predicted table
  typedef struct {
    mode_e             mode;
    logic [TIME_W-1:0] remaining;
    logic [TIME_W-1:0] reload;
    logic [REP_W-1:0]  repeats;
  } timer_slot_t;

  // table predictor and in-order response checker
  class timer_table_checker;
    timer_slot_t slots[SLOTS];
    res_t        expected_q[$];
    int          failures;

    function new();
      failures = 0;
      foreach (slots[s]) free_slot(s);
    endfunction

    function void free_slot(int s);
      slots[s] = '{MODE_FREE, '0, '0, '0};
    endfunction

    // one sweep of the table, returns the slots that expired
    function logic [MASK_W-1:0] sweep_tick();
      logic [MASK_W-1:0] expired;
      expired = '0;
      for (int s = 0; s < SLOTS; s++) begin
        if (slots[s].mode == MODE_STOPPED && slots[s].repeats == 0) free_slot(s);
        if (slots[s].mode == MODE_RUNNING && slots[s].remaining != 0) begin
          slots[s].remaining = slots[s].remaining - 1'b1;
          if (slots[s].remaining == 0) begin
            if (slots[s].repeats == REPEAT_FOREVER) begin
              slots[s].remaining = slots[s].reload;
            end else if (slots[s].repeats != 0) begin
              slots[s].remaining = slots[s].reload;
              slots[s].repeats   = slots[s].repeats - 1'b1;
            end
            if (slots[s].repeats == 0) slots[s].mode = MODE_STOPPED;
            if (s < MASK_W) expired[s] = 1'b1;
          end
        end
      end
      return expired;
    endfunction

    // apply one accepted request and queue the response it must produce
    function void note_request(logic [CMD_W-1:0] cmd, logic [SLOT_FLD_W-1:0] slot,
                               logic [TIME_W-1:0] interval, logic [REP_W-1:0] count,
                               logic [VALUE_W-1:0] tval);
      res_t r;
      r = '0;
      if (cmd == CMD_TICK) begin
        r.expired_mask = sweep_tick();
        if (r.expired_mask != 0) r.expired_value = tval;
      end else if (cmd == CMD_ADD) begin
        r.table_full = 1'b1;
        for (int s = 0; s < SLOTS; s++) begin
          if (slots[s].mode == MODE_FREE) begin
            slots[s] = '{MODE_STOPPED, interval, interval, count};
            r.granted_slot = s[GRANT_W-1:0];
            r.table_full = 1'b0;
            break;
          end
        end
      end else if (slot < SLOTS) begin
        if (cmd == CMD_START && slots[slot].mode != MODE_FREE) begin
          slots[slot].remaining = slots[slot].reload;
          slots[slot].mode = MODE_RUNNING;
        end else if (cmd == CMD_STOP && slots[slot].mode != MODE_FREE) begin
          slots[slot].mode = MODE_STOPPED;
        end else if (cmd == CMD_DELETE) begin
          free_slot(slot);
        end
      end
      expected_q.push_back(r);
    endfunction

    // compare one response against the oldest expectation
    function void check_result(logic [OUT_DATA_W-1:0] data);
      res_t got, exp_r;
      got = res_t'(data[$bits(res_t)-1:0]);
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected response %h", $time, data);
        failures++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.granted_slot !== exp_r.granted_slot) begin
        $display("%0t: granted_slot expected %0d actual %0d", $time,
                 exp_r.granted_slot, got.granted_slot);
        failures++;
      end
      if (got.table_full !== exp_r.table_full) begin
        $display("%0t: table_full expected %0d actual %0d", $time,
                 exp_r.table_full, got.table_full);
        failures++;
      end
      if (got.expired_mask !== exp_r.expired_mask) begin
        $display("%0t: expired_mask expected %h actual %h", $time,
                 exp_r.expired_mask, got.expired_mask);
        failures++;
      end
      if (got.expired_value !== exp_r.expired_value) begin
        $display("%0t: expired_value expected %h actual %h", $time,
                 exp_r.expired_value, got.expired_value);
        failures++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // mostly an occupied slot, so start, stop and delete do real work
    function logic [SLOT_FLD_W-1:0] pick_slot();
      int used[$];
      foreach (slots[s]) if (slots[s].mode != MODE_FREE) used.push_back(s);
      if (used.size() == 0 || $urandom_range(99) < 20) begin
        return SLOT_FLD_W'($urandom_range(15));
      end
      return SLOT_FLD_W'(used[$urandom_range(used.size() - 1)]);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // slot, interval, repeat_count, tick_value
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;  // cmd
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;       // granted_slot, table_full, expired_mask,
                                             // expired_value

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  timer_table_checker table_chk;

  multi_slot_repeating_timer_table dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // response side: check on handshake, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) table_chk.check_result(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // issue one request, with random idle cycles ahead of it
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [SLOT_FLD_W-1:0] slot,
                              logic [TIME_W-1:0] interval, logic [REP_W-1:0] count,
                              logic [VALUE_W-1:0] tval);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, tval, count, interval, slot};
    s_axis_tuser  <= {{(IN_USER_W-CMD_W){1'b0}}, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    table_chk.note_request(cmd, slot, interval, count, tval);
  endtask

  // hold off until every queued response is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (table_chk.pending() != 0) @(posedge clk_i);
  endtask

  // random traffic, add_pct steers how full the table gets
  task automatic run_random(int n, int add_pct);
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] interval;
    logic [REP_W-1:0]  count;
    int                r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < add_pct)                 cmd = CMD_ADD;
      else if (r < add_pct + 20)       cmd = CMD_START;
      else if (r < add_pct + 30)       cmd = CMD_STOP;
      else if (r < add_pct + 38)       cmd = CMD_DELETE;
      else if (r < 96)                 cmd = CMD_TICK;
      else cmd = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
      // short intervals so timers actually expire, some full range
      r = $urandom_range(99);
      if (r < 70)      interval = TIME_W'($urandom_range(4));
      else if (r < 90) interval = TIME_W'($urandom_range(40));
      else             interval = TIME_W'($urandom());
      r = $urandom_range(99);
      if (r < 60)      count = REP_W'($urandom_range(3));
      else if (r < 80) count = REPEAT_FOREVER;
      else             count = REP_W'($urandom_range(255));
      send_request(cmd, table_chk.pick_slot(), interval, count, VALUE_W'($urandom()));
    end
  endtask

  initial begin
    table_chk = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty tick, adds at the extremes, expiry corner cases
    send_request(CMD_TICK,   4'd0,  16'd0,     8'd0,   16'd0);
    send_request(CMD_ADD,    4'd0,  16'd1,     8'd0,   16'd0);
    send_request(CMD_ADD,    4'd0,  16'hFFFF,  REPEAT_FOREVER, 16'd0);
    send_request(CMD_ADD,    4'd0,  16'd0,     8'd3,   16'd0);
    send_request(CMD_ADD,    4'd0,  16'd2,     8'd1,   16'd0);
    send_request(CMD_ADD,    4'd0,  16'd1,     REPEAT_FOREVER, 16'd0);
    send_request(CMD_START,  4'd0,  16'd0,     8'd0,   16'd0);
    send_request(CMD_START,  4'd2,  16'd0,     8'd0,   16'd0);
    send_request(CMD_START,  4'd3,  16'd0,     8'd0,   16'd0);
    send_request(CMD_START,  4'd4,  16'd0,     8'd0,   16'd0);
    send_request(CMD_START,  4'd1,  16'd0,     8'd0,   16'd0);
    send_request(CMD_TICK,   4'd0,  16'd0,     8'd0,   16'hFFFF);
    send_request(CMD_TICK,   4'd0,  16'd0,     8'd0,   16'h0001);
    send_request(CMD_STOP,   4'd4,  16'd0,     8'd0,   16'd0);
    send_request(CMD_TICK,   4'd0,  16'd0,     8'd0,   16'h8000);
    send_request(CMD_DELETE, 4'd1,  16'd0,     8'd0,   16'd0);
    // start and stop of free slots, unused codes, delete of a free slot
    send_request(CMD_START,  4'd5,  16'd0,     8'd0,   16'd0);
    send_request(CMD_STOP,   4'd6,  16'd0,     8'd0,   16'd0);
    send_request(CMD_RSVD_FIRST, 4'd4, 16'd0,  8'd0,   16'd0);
    send_request(CMD_RSVD_LAST, 4'hF, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_request(CMD_DELETE, 4'hF,  16'd0,     8'd0,   16'd0);
    send_request(CMD_START,  4'd4,  16'd0,     8'd0,   16'd0);
    send_request(CMD_TICK,   4'd0,  16'd0,     8'd0,   16'h5A5A);
    send_request(CMD_ADD,    4'hF,  16'hFFFF,  8'd0,   16'hFFFF);
    drain();

    // random phases: no idling, sender idle, receiver stall, both
    run_random(270, 45);
    drain();
    send_idle_pct = 45;
    run_random(270, 30);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 45;
    run_random(270, 30);
    drain();
    send_idle_pct = 16;
    recv_stall_pct = 16;
    run_random(270, 35);
    drain();

    repeat (40) @(posedge clk_i);
    if (table_chk.failures == 0 && table_chk.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
